>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the LED controller design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, disabled while reset is low.
`define JLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check on the rising clock edge.
`define JLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/jlc_pkg.sv
// ----------------------------------------------------------------------------
// jlc_pkg
// Types, register codes and constants of the joystick LED controller.
// ----------------------------------------------------------------------------
`default_nettype none

package jlc_pkg;

  // Field widths.
  localparam int unsigned BtnW      = 5;
  localparam int unsigned LedW      = 4;
  localparam int unsigned DbTicksW  = 15;
  localparam int unsigned BlTicksW  = 17;
  localparam int unsigned DbCountW  = 16;
  localparam int unsigned BlCountW  = 18;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  // Button bit positions in the pressed word.
  localparam int unsigned BtnLeft   = 0;
  localparam int unsigned BtnUp     = 1;
  localparam int unsigned BtnDown   = 2;
  localparam int unsigned BtnRight  = 3;
  localparam int unsigned BtnCenter = 4;

  // LED patterns.
  localparam logic [LedW-1:0] LedsAll   = 4'hF;
  localparam logic [LedW-1:0] LedsNone  = 4'h0;
  localparam logic [LedW-1:0] LedFirst  = 4'h1;
  localparam logic [LedW-1:0] LedLast   = 4'h8;

  // Register reset values.
  localparam logic [DbTicksW-1:0] DbTicksRst = 15'd20000;
  localparam logic [BlTicksW-1:0] BlTicksRst = 17'd80000;

  // Register index codes, taken from address bit 2.
  typedef enum logic {
    REG_DEBOUNCE_TICKS = 1'b0,
    REG_BLINK_TICKS    = 1'b1
  } reg_idx_e;

  // Configuration handed from the register block to the datapath.
  typedef struct packed {
    logic [DbTicksW-1:0] debounce_ticks;
    logic [BlTicksW-1:0] blink_ticks;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/jlc_apb_regs.sv
// ----------------------------------------------------------------------------
// jlc_apb_regs
// APB configuration registers: debounce hold length and blink on length.
// ----------------------------------------------------------------------------
`default_nettype none

module jlc_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [jlc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [jlc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [jlc_pkg::ApbDataW-1:0]    prdata,
  output logic                                 pready,
  output jlc_pkg::cfg_t                        cfg_o
);

  jlc_pkg::cfg_t    cfg_q, cfg_d;
  jlc_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = jlc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        jlc_pkg::REG_DEBOUNCE_TICKS:
          cfg_d.debounce_ticks = pwdata[jlc_pkg::DbTicksW-1:0];
        jlc_pkg::REG_BLINK_TICKS:
          cfg_d.blink_ticks = pwdata[jlc_pkg::BlTicksW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= jlc_pkg::DbTicksRst;
      cfg_q.blink_ticks    <= jlc_pkg::BlTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      jlc_pkg::REG_DEBOUNCE_TICKS:
        prdata = {{(jlc_pkg::ApbDataW-jlc_pkg::DbTicksW){1'b0}}, cfg_q.debounce_ticks};
      jlc_pkg::REG_BLINK_TICKS:
        prdata = {{(jlc_pkg::ApbDataW-jlc_pkg::BlTicksW){1'b0}}, cfg_q.blink_ticks};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/jlc_debounce.sv
// ----------------------------------------------------------------------------
// jlc_debounce
// Debounce sequencer and button actions on the LED pattern and blink mode.
// ----------------------------------------------------------------------------
`default_nettype none

module jlc_debounce (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic [jlc_pkg::BtnW-1:0]        buttons_i,
  input  wire logic [jlc_pkg::DbTicksW-1:0]    debounce_ticks_i,
  output logic      [jlc_pkg::LedW-1:0]        pattern_o,
  output logic                                 blinking_o
);

  logic [jlc_pkg::DbCountW-1:0] count_q, count_d;
  logic [jlc_pkg::LedW-1:0]     pattern_q, pattern_d;
  logic                         blinking_q, blinking_d;
  logic [jlc_pkg::DbTicksW-1:0] ticks;
  logic [jlc_pkg::DbCountW-1:0] hold, hold2;
  logic [jlc_pkg::LedW-1:0]     pat_up, pat_down;
  logic [jlc_pkg::LedW:0]       pat_shl;
  logic                         any_btn;

  // A zero hold length behaves as one tick.
  assign ticks   = (debounce_ticks_i == '0) ? jlc_pkg::DbTicksW'(1) : debounce_ticks_i;
  assign hold    = {1'b0, ticks};
  assign hold2   = {ticks, 1'b0};
  assign any_btn = |buttons_i;

  // Rotations of the one-hot pattern; all-on or all-off restarts at an end.
  assign pat_shl = {pattern_q, 1'b0};
  always_comb begin
    if (pattern_q == jlc_pkg::LedsAll || pattern_q == jlc_pkg::LedsNone) begin
      pat_up   = jlc_pkg::LedLast;
      pat_down = jlc_pkg::LedFirst;
    end else begin
      pat_up   = (pattern_q[jlc_pkg::LedW-1:1] == '0) ? jlc_pkg::LedLast
                                                      : (pattern_q >> 1);
      pat_down = (pat_shl > {1'b0, jlc_pkg::LedLast}) ? jlc_pkg::LedFirst
                                                      : pat_shl[jlc_pkg::LedW-1:0];
    end
  end

  // Counter phases and button actions, in priority order.
  always_comb begin
    count_d    = count_q;
    pattern_d  = pattern_q;
    blinking_d = blinking_q;
    if (any_btn && count_q == '0) begin
      count_d = jlc_pkg::DbCountW'(1);
      if (buttons_i[jlc_pkg::BtnUp]) begin
        pattern_d = pat_up;
      end else if (buttons_i[jlc_pkg::BtnDown]) begin
        pattern_d = pat_down;
      end else if (buttons_i[jlc_pkg::BtnLeft]) begin
        pattern_d = jlc_pkg::LedsAll;
      end else if (buttons_i[jlc_pkg::BtnRight]) begin
        pattern_d = jlc_pkg::LedsNone;
      end else begin
        blinking_d = ~blinking_q;
      end
    end else if (count_q != '0 && count_q < hold) begin
      count_d = count_q + 1'b1;
    end else if (!any_btn && count_q == hold) begin
      count_d = count_q + 1'b1;
    end else if (count_q > hold && count_q < hold2) begin
      count_d = count_q + 1'b1;
    end else if (!any_btn && count_q >= hold2) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      pattern_q  <= jlc_pkg::LedFirst;
      blinking_q <= 1'b0;
    end else if (step_i) begin
      count_q    <= count_d;
      pattern_q  <= pattern_d;
      blinking_q <= blinking_d;
    end
  end

  // The result reflects the state after this tick.
  assign pattern_o  = pattern_d;
  assign blinking_o = blinking_d;

endmodule

`default_nettype wire

>>> design/jlc_blink.sv
// ----------------------------------------------------------------------------
// jlc_blink
// Blink phase counter that gates the LED drive while blinking is on.
// ----------------------------------------------------------------------------
`default_nettype none

module jlc_blink (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            step_i,
  input  wire logic                            blinking_i,
  input  wire logic [jlc_pkg::BlTicksW-1:0]    blink_ticks_i,
  output logic                                 on_o
);

  logic [jlc_pkg::BlCountW-1:0] count_q, count_d;
  logic [jlc_pkg::BlCountW:0]   count_inc;
  logic [jlc_pkg::BlCountW:0]   limit;

  // The drive is on in the first phase, or always when not blinking.
  assign on_o = (count_q < {1'b0, blink_ticks_i}) || !blinking_i;

  // Wrap to zero once the count passes twice the on length.
  assign count_inc = {1'b0, count_q} + 1'b1;
  assign limit     = {1'b0, blink_ticks_i, 1'b0};
  assign count_d   = (count_inc > limit) ? '0 : count_inc[jlc_pkg::BlCountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (step_i) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> design/debounced_joystick_led_controller.sv
// ----------------------------------------------------------------------------
// debounced_joystick_led_controller
// Debounced five-button joystick driving a four-LED pattern with blinking.
// ----------------------------------------------------------------------------
//   Channel   Dir  Word contents (lowest bit first)
//   s_axis    in   tdata[4:0] buttons_pressed
//   m_axis    out  tdata[3:0] led_drive, [7:4] led_pattern, [8] blink_enabled
//   apb       cfg  0x0 debounce_ticks, 0x4 blink_ticks
//
// One word per cycle while the output is not stalled: each accepted word
// updates the debounce, pattern and blink state in a single pass and loads
// the output register in the same edge; its word is valid in the next cycle.
// A stalled output holds its word; input is taken whenever the output
// register is empty or being drained in that cycle.
// Reset clears all but the output data at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_joystick_led_controller (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input stream: [4:0] buttons_pressed.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,
  // Output stream: [3:0] led_drive, [7:4] led_pattern, [8] blink_enabled.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [15:0]                     m_axis_tdata,
  // Configuration port.
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [jlc_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [jlc_pkg::ApbDataW-1:0]    pwdata,
  output logic      [jlc_pkg::ApbDataW-1:0]    prdata,
  output logic                                 pready
);

  jlc_pkg::cfg_t             cfg;
  logic                      step;
  logic [jlc_pkg::LedW-1:0]  pattern;
  logic                      blinking;
  logic                      led_on;
  logic                      out_valid_q, out_valid_d;
  logic [jlc_pkg::LedW-1:0]  drive_q, pattern_q;
  logic                      blink_q;

  // Configuration registers.
  jlc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept whenever the output register is free this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;

  jlc_debounce u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .buttons_i        (s_axis_tdata[jlc_pkg::BtnW-1:0]),
    .debounce_ticks_i (cfg.debounce_ticks),
    .pattern_o        (pattern),
    .blinking_o       (blinking)
  );

  jlc_blink u_blink (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .blinking_i    (blinking),
    .blink_ticks_i (cfg.blink_ticks),
    .on_o          (led_on)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      drive_q   <= led_on ? pattern : jlc_pkg::LedsNone;
      pattern_q <= pattern;
      blink_q   <= blinking;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, blink_q, pattern_q, drive_q};

  // Checks.
`include "assert_macros.svh"

  `JLC_ASSERT_NEXT(a_accept_gives_word, step, m_axis_tvalid, "accepted word produced no output")
  `JLC_ASSERT_IMP(a_drive_gated, m_axis_tvalid,
    (drive_q == jlc_pkg::LedsNone || drive_q == pattern_q), "drive is not pattern or dark")
  `JLC_ASSERT_IMP(a_no_blink_full, m_axis_tvalid && !blink_q, drive_q == pattern_q,
    "drive gated while blinking is off")
  `JLC_ASSERT_IMP(a_pattern_legal, m_axis_tvalid,
    ($onehot0(pattern_q) || pattern_q == jlc_pkg::LedsAll), "illegal LED pattern")

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the debounced joystick LED controller. Button
// words go in on the input stream, each one predicted in the bench as one
// tick of debounce, pattern and blink state, and every output word is checked
// field by field against the oldest prediction. Both stream sides idle and
// stall at random, and the registers are rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import jlc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandomWords = 1780;

  // One expected output word.
  typedef struct packed {
    logic [LedW-1:0] drive;
    logic [LedW-1:0] pattern;
    logic            blink;
  } led_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [4:0] buttons_pressed
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [3:0] led_drive, [7:4] led_pattern, [8] blink
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Bench copy of the controller state and its registers.
  logic [DbTicksW-1:0] db_ticks;
  logic [BlTicksW-1:0] bl_ticks;
  logic [DbCountW-1:0] db_cnt;
  logic [BlCountW-1:0] bl_cnt;
  logic [LedW-1:0]     led_pat;
  logic                blinking;

  led_word_t   led_q[$];
  led_word_t   want;
  int unsigned err_cnt;
  int unsigned cycles;
  int unsigned words_in;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned hold_len;
  int unsigned hold_cnt;
  int unsigned stall_cnt;

  debounced_joystick_led_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BtnW-1:0] rand_btn();
    logic [BtnW-1:0] b;
    b = $urandom_range(0, 31);
    return b;
  endfunction

  // Mostly a single button, sometimes a random chord.
  function automatic logic [BtnW-1:0] pick_buttons();
    logic [BtnW-1:0] b;
    if ($urandom_range(0, 9) < 7) begin
      b = 5'd1 << $urandom_range(0, 4);
    end else begin
      b = $urandom_range(1, 31);
    end
    return b;
  endfunction

  function automatic int unsigned hold_ticks();
    return (db_ticks == 0) ? 1 : int'(db_ticks);
  endfunction

  // One tick of the controller: debounce and buttons, then drive and blink.
  function automatic led_word_t led_tick(input logic [BtnW-1:0] btn);
    int unsigned t;
    int unsigned bt;
    int unsigned nxt;
    logic [LedW:0] wide;
    led_word_t w;
    t = hold_ticks();
    bt = bl_ticks;
    if (btn != 0 && db_cnt == 0) begin
      db_cnt = 1;
      if (btn[BtnUp]) begin
        if (led_pat == LedsAll || led_pat == LedsNone) begin
          led_pat = LedLast;
        end else begin
          led_pat = led_pat >> 1;
          if (led_pat == LedsNone) led_pat = LedLast;
        end
      end else if (btn[BtnDown]) begin
        if (led_pat == LedsAll || led_pat == LedsNone) begin
          led_pat = LedFirst;
        end else begin
          wide = {1'b0, led_pat} << 1;
          led_pat = (wide > 5'd8) ? LedFirst : wide[LedW-1:0];
        end
      end else if (btn[BtnLeft]) begin
        led_pat = LedsAll;
      end else if (btn[BtnRight]) begin
        led_pat = LedsNone;
      end else if (btn[BtnCenter]) begin
        blinking = !blinking;
      end
    end else if (db_cnt > 0 && db_cnt < t) begin
      db_cnt = db_cnt + 1;
    end else if (btn == 0 && db_cnt == t) begin
      db_cnt = db_cnt + 1;
    end else if (db_cnt > t && db_cnt < 2 * t) begin
      db_cnt = db_cnt + 1;
    end else if (btn == 0 && db_cnt >= 2 * t) begin
      db_cnt = 0;
    end
    w.drive = (bl_cnt < bt || !blinking) ? led_pat : LedsNone;
    w.pattern = led_pat;
    w.blink = blinking;
    nxt = bl_cnt + 1;
    if (nxt > 2 * bt) nxt = 0;
    bl_cnt = nxt[BlCountW-1:0];
    return w;
  endfunction

  // Offer one button word and predict its result once it is taken.
  task automatic send(input logic [BtnW-1:0] btn);
    int unsigned gap;
    gap = tx_idle_en ? rand_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, btn};
    do @(posedge clk_i); while (!s_axis_tready);
    led_q.push_back(led_tick(btn));
    words_in++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted word has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (led_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // One register access; the bus is left idle afterwards.
  task automatic apb_access(input logic wr, input reg_idx_e idx,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Read a register back and compare it with the bench copy.
  task automatic check_reg(input reg_idx_e idx);
    logic [ApbDataW-1:0] rd;
    logic [ApbDataW-1:0] exp_rd;
    apb_access(1'b0, idx, '0, rd);
    exp_rd = (idx == REG_DEBOUNCE_TICKS) ? {17'd0, db_ticks} : {15'd0, bl_ticks};
    if (rd !== exp_rd) begin
      $error("prdata[%s]: expected %0d, actual %0d", idx.name(), exp_rd, rd);
      err_cnt++;
    end
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned val);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b1, idx, val, rd);
    if (idx == REG_DEBOUNCE_TICKS) begin
      db_ticks = val[DbTicksW-1:0];
    end else begin
      bl_ticks = val[BlTicksW-1:0];
    end
    check_reg(idx);
  endtask

  // A clean press, held for a while, then released for a random stretch,
  // with the odd bounce mixed in.
  task automatic press_and_release();
    int unsigned t;
    int unsigned n_hold;
    int unsigned n_rel;
    logic [BtnW-1:0] btn;
    t = hold_ticks();
    btn = pick_buttons();
    n_hold = $urandom_range(1, t + 2);
    n_rel = $urandom_range(t, 2 * t + 3);
    repeat (n_hold) send(($urandom_range(0, 9) == 0) ? rand_btn() : btn);
    repeat (n_rel) send(($urandom_range(0, 19) == 0) ? rand_btn() : 5'd0);
  endtask

  // Register values after reset, and a press under the long default hold.
  task automatic test_reset_state();
    check_reg(REG_DEBOUNCE_TICKS);
    check_reg(REG_BLINK_TICKS);
    send(5'd1 << BtnUp);
    send(5'd1 << BtnDown);
    repeat (3) send(5'd0);
  endtask

  // Every button at least once with the shortest hold, wraps and the all/none restarts.
  task automatic test_each_button();
    logic [BtnW-1:0] seq[12];
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 1);
    seq = '{5'd1 << BtnDown, 5'd1 << BtnUp, 5'd1 << BtnLeft, 5'd1 << BtnUp,
            5'd1 << BtnLeft, 5'd1 << BtnDown, 5'd1 << BtnRight, 5'd1 << BtnUp,
            5'd1 << BtnRight, 5'd1 << BtnDown, 5'd1 << BtnCenter, 5'h1F};
    send(5'd0);
    foreach (seq[i]) begin
      send(seq[i]);
      send(5'd0);
      send(5'd0);
    end
  endtask

  task automatic test_special_cases();
    drain();
    // A zero hold behaves as a hold of one tick.
    write_reg(REG_DEBOUNCE_TICKS, 0);
    send(5'd1 << BtnLeft);
    repeat (2) send(5'd0);
    // With a zero on phase the drive stays dark while blinking.
    drain();
    write_reg(REG_BLINK_TICKS, 0);
    send(5'd1 << BtnCenter);
    repeat (4) send(5'd0);
    send(5'd1 << BtnCenter);
    repeat (2) send(5'd0);
    // Debounce counter left beyond a hold that has since been shortened.
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 10);
    send(5'd1 << BtnUp);
    repeat (14) send(5'd0);
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 2);
    repeat (2) send(5'd0);
    send(5'd1 << BtnDown);
    repeat (5) send(5'd0);
    // Blink counter left beyond a period that has since been shortened.
    drain();
    write_reg(REG_BLINK_TICKS, 20);
    send(5'd1 << BtnCenter);
    while (bl_cnt <= 10) send(5'd0);
    drain();
    write_reg(REG_BLINK_TICKS, 2);
    repeat (8) send(5'd0);
  endtask

  // Largest hold and blink period.
  task automatic test_config_extremes();
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 32767);
    write_reg(REG_BLINK_TICKS, 131071);
    repeat (4) send(5'd0);
    send(5'd1 << BtnDown);
    repeat (4) send(5'd1 << BtnUp);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    drain();
    write_reg(REG_DEBOUNCE_TICKS, 2);
    write_reg(REG_BLINK_TICKS, 3);
    tx_idle_en = 1'b0;
    hold_len = 80;
    repeat (8) press_and_release();
    tx_idle_en = 1'b1;
  endtask

  // Phases of random settings, mostly well-formed presses, some noise.
  task automatic test_random();
    int unsigned stop_at;
    int unsigned phase_end;
    stop_at = words_in + RandomWords;
    while (words_in < stop_at) begin
      drain();
      write_reg(REG_DEBOUNCE_TICKS, ($urandom_range(0, 4) == 0) ?
                $urandom_range(7, 40) : $urandom_range(0, 6));
      write_reg(REG_BLINK_TICKS, ($urandom_range(0, 4) == 0) ?
                $urandom_range(11, 300) : $urandom_range(0, 10));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      phase_end = words_in + 240;
      while (words_in < phase_end && words_in < stop_at) begin
        if ($urandom_range(0, 99) < 85) begin
          press_and_release();
        end else begin
          repeat ($urandom_range(1, 8)) send(rand_btn());
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver: a requested long hold-off first, else random stalls.
  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt > 0) begin
      m_axis_tready <= 1'b0;
      hold_cnt--;
    end else if (stall_cnt > 0) begin
      m_axis_tready <= 1'b0;
      stall_cnt--;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_idle_en) stall_cnt = rand_gap();
    end
  end

  // Compare each output word with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (led_q.size() == 0) begin
        $error("output word %h with nothing expected", m_axis_tdata);
        err_cnt++;
      end else begin
        want = led_q.pop_front();
        if (m_axis_tdata[3:0] !== want.drive) begin
          $error("led_drive: expected %h, actual %h", want.drive, m_axis_tdata[3:0]);
          err_cnt++;
        end
        if (m_axis_tdata[7:4] !== want.pattern) begin
          $error("led_pattern: expected %h, actual %h", want.pattern, m_axis_tdata[7:4]);
          err_cnt++;
        end
        if (m_axis_tdata[8] !== want.blink) begin
          $error("blink_enabled: expected %b, actual %b", want.blink, m_axis_tdata[8]);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    cycles = 0;
    words_in = 0;
    hold_len = 0;
    hold_cnt = 0;
    stall_cnt = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    db_ticks = DbTicksRst;
    bl_ticks = BlTicksRst;
    db_cnt = '0;
    bl_cnt = '0;
    led_pat = LedFirst;
    blinking = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_state();
    test_each_button();
    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random();

    drain();
    repeat (5) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
